// File: hdl/cpid_pkg.sv
// Shared types, constants and microprogram of the cascade PID controller.
package cpid_pkg;

    localparam int DATA_W    = 32;
    localparam int LIM_W     = 31;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 4;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_ERR,
        OP_DIFF,
        OP_TERM_FIRST,
        OP_TERM_ADD,
        OP_INTEG,
        OP_SUM,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_KP_ERR,
        MUL_KD_DIFF,
        MUL_KI_ERR
    } t_mul_sel;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_WAIT_IN,
        JMP_WAIT_OUT
    } t_jmp;

    typedef enum logic {
        LOOP_OUTER,
        LOOP_INNER
    } t_loop;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUTER_KP,
        CFG_OUTER_KI,
        CFG_OUTER_KD,
        CFG_INNER_KP,
        CFG_INNER_KI,
        CFG_INNER_KD,
        CFG_OUTER_OUT_LIMIT,
        CFG_INNER_OUT_LIMIT
    } t_cfg_idx;

    typedef struct packed {
        t_op              op;
        t_loop            loop;
        t_mul_sel         mul;
        t_jmp             jmp;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    localparam logic [STEP_W-1:0] STEP_IDLE = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_EMIT = STEP_W'(13);

    // Control store: one word per step.
    function automatic t_ctrl ucode(input logic [STEP_W-1:0] step);
        t_ctrl w;
        w = '{op: OP_NOP, loop: LOOP_OUTER, mul: MUL_NONE, jmp: JMP_NEXT, target: STEP_IDLE};
        case (step)
            4'd0:  w = '{OP_LOAD,       LOOP_OUTER, MUL_NONE,    JMP_WAIT_IN,  STEP_IDLE};
            4'd1:  w = '{OP_ERR,        LOOP_OUTER, MUL_NONE,    JMP_NEXT,     STEP_IDLE};
            4'd2:  w = '{OP_DIFF,       LOOP_OUTER, MUL_KP_ERR,  JMP_NEXT,     STEP_IDLE};
            4'd3:  w = '{OP_TERM_FIRST, LOOP_OUTER, MUL_KD_DIFF, JMP_NEXT,     STEP_IDLE};
            4'd4:  w = '{OP_TERM_ADD,   LOOP_OUTER, MUL_KI_ERR,  JMP_NEXT,     STEP_IDLE};
            4'd5:  w = '{OP_INTEG,      LOOP_OUTER, MUL_NONE,    JMP_NEXT,     STEP_IDLE};
            4'd6:  w = '{OP_SUM,        LOOP_OUTER, MUL_NONE,    JMP_NEXT,     STEP_IDLE};
            4'd7:  w = '{OP_ERR,        LOOP_INNER, MUL_NONE,    JMP_NEXT,     STEP_IDLE};
            4'd8:  w = '{OP_DIFF,       LOOP_INNER, MUL_KP_ERR,  JMP_NEXT,     STEP_IDLE};
            4'd9:  w = '{OP_TERM_FIRST, LOOP_INNER, MUL_KD_DIFF, JMP_NEXT,     STEP_IDLE};
            4'd10: w = '{OP_TERM_ADD,   LOOP_INNER, MUL_KI_ERR,  JMP_NEXT,     STEP_IDLE};
            4'd11: w = '{OP_INTEG,      LOOP_INNER, MUL_NONE,    JMP_NEXT,     STEP_IDLE};
            4'd12: w = '{OP_SUM,        LOOP_INNER, MUL_NONE,    JMP_NEXT,     STEP_IDLE};
            4'd13: w = '{OP_EMIT,       LOOP_OUTER, MUL_NONE,    JMP_WAIT_OUT, STEP_IDLE};
            default: w = '{OP_NOP,      LOOP_OUTER, MUL_NONE,    JMP_GOTO,     STEP_IDLE};
        endcase
        return w;
    endfunction

    // Saturate a 33-bit signed value to 32 bits.
    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1]) begin
            r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/cpid_datapath.sv
// Datapath of the cascade PID: config registers, loop state, shared multiplier, adder and clamps.
module cpid_datapath #(
    parameter int OUTER_INT_LIMIT = 65536000,
    parameter int INNER_INT_LIMIT = 65536000,
    parameter int OUTER_DEADZONE  = 0,
    parameter int INNER_DEADZONE  = 0,
    parameter int FRAC_BITS       = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cpid_pkg::t_ctrl                     i_ctrl,
    input  logic                                i_fire,
    input  logic                                i_cfg_we,
    input  logic [cpid_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cpid_pkg::DATA_W-1:0]         i_cfg_data,
    input  logic signed [cpid_pkg::DATA_W-1:0]  i_angle_setpoint,
    input  logic signed [cpid_pkg::DATA_W-1:0]  i_angle_measured,
    input  logic signed [cpid_pkg::DATA_W-1:0]  i_speed_measured,
    input  logic                                i_clear_history,
    output logic signed [cpid_pkg::DATA_W-1:0]  o_drive_value,
    output logic signed [cpid_pkg::DATA_W-1:0]  o_speed_setpoint
);

    localparam int W   = cpid_pkg::DATA_W;
    localparam int LW  = cpid_pkg::LIM_W;
    localparam int ACW = W + 2;

    localparam logic signed [ACW-1:0] OUTER_IL = ACW'(OUTER_INT_LIMIT);
    localparam logic signed [ACW-1:0] INNER_IL = ACW'(INNER_INT_LIMIT);
    localparam logic [W:0]            OUTER_DZ = (W+1)'(OUTER_DEADZONE);
    localparam logic [W:0]            INNER_DZ = (W+1)'(INNER_DEADZONE);

    // configuration, indexed by loop
    logic signed [W-1:0]  r_kp [2];
    logic signed [W-1:0]  r_ki [2];
    logic signed [W-1:0]  r_kd [2];
    logic [LW-1:0]        r_out_lim [2];

    // loop history
    logic signed [W-1:0]  r_prev [2];
    logic signed [W-1:0]  r_integ [2];

    // working registers
    logic signed [W-1:0]     r_sp, r_am, r_sm;
    logic signed [W-1:0]     r_err, r_dd, r_spd, r_drv;
    logic signed [2*W-1:0]   r_prod;
    logic signed [ACW-1:0]   r_acc;

    logic                    lp;
    logic signed [W-1:0]     ref_v, fdb_v;
    logic signed [W:0]       diff;
    logic [W:0]              mag;
    logic [W:0]              dz;
    logic signed [W-1:0]     err_v, dd_v;
    logic signed [W-1:0]     mul_a, mul_b;
    logic signed [2*W-1:0]   prod_sh;
    logic signed [W-1:0]     term;
    logic signed [ACW-1:0]   il, integ_sum, integ_v;
    logic signed [ACW-1:0]   ol, out_sum;
    logic signed [W-1:0]     out_v;

    assign lp = i_ctrl.loop;

    always_comb begin
        ref_v = (lp == cpid_pkg::LOOP_INNER) ? r_spd : r_sp;
        fdb_v = (lp == cpid_pkg::LOOP_INNER) ? r_sm : r_am;
        dz    = (lp == cpid_pkg::LOOP_INNER) ? INNER_DZ : OUTER_DZ;
        il    = (lp == cpid_pkg::LOOP_INNER) ? INNER_IL : OUTER_IL;
        ol    = ACW'({1'b0, r_out_lim[lp]});

        diff  = (W+1)'(ref_v) - (W+1)'(fdb_v);
        mag   = diff[W] ? (W+1)'(-diff) : (W+1)'(diff);
        err_v = (mag < dz) ? '0 : cpid_pkg::sat33(diff);
        dd_v  = cpid_pkg::sat33((W+1)'(r_err) - (W+1)'(r_prev[lp]));

        mul_a = r_err;
        mul_b = r_kp[lp];
        case (i_ctrl.mul)
            cpid_pkg::MUL_KD_DIFF: begin
                mul_a = r_dd;
                mul_b = r_kd[lp];
            end
            cpid_pkg::MUL_KI_ERR: begin
                mul_b = r_ki[lp];
            end
            default: begin
            end
        endcase

        // arithmetic shift floors toward minus infinity
        prod_sh = r_prod >>> FRAC_BITS;
        if (prod_sh[2*W-1:W-1] == '0 || prod_sh[2*W-1:W-1] == '1) begin
            term = prod_sh[W-1:0];
        end else begin
            term = prod_sh[2*W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end

        integ_sum = ACW'(r_integ[lp]) + ACW'(term);
        if (integ_sum < -il) begin
            integ_v = -il;
        end else if (integ_sum > il) begin
            integ_v = il;
        end else begin
            integ_v = integ_sum;
        end

        out_sum = r_acc + ACW'(r_integ[lp]);
        if (out_sum < -ol) begin
            out_v = W'(-ol);
        end else if (out_sum > ol) begin
            out_v = W'(ol);
        end else begin
            out_v = W'(out_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_kp[i]      <= '0;
                r_ki[i]      <= '0;
                r_kd[i]      <= '0;
                r_out_lim[i] <= '0;
                r_prev[i]    <= '0;
                r_integ[i]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (cpid_pkg::t_cfg_idx'(i_cfg_index))
                    cpid_pkg::CFG_OUTER_KP:        r_kp[0]      <= i_cfg_data;
                    cpid_pkg::CFG_OUTER_KI:        r_ki[0]      <= i_cfg_data;
                    cpid_pkg::CFG_OUTER_KD:        r_kd[0]      <= i_cfg_data;
                    cpid_pkg::CFG_INNER_KP:        r_kp[1]      <= i_cfg_data;
                    cpid_pkg::CFG_INNER_KI:        r_ki[1]      <= i_cfg_data;
                    cpid_pkg::CFG_INNER_KD:        r_kd[1]      <= i_cfg_data;
                    cpid_pkg::CFG_OUTER_OUT_LIMIT: r_out_lim[0] <= i_cfg_data[LW-1:0];
                    cpid_pkg::CFG_INNER_OUT_LIMIT: r_out_lim[1] <= i_cfg_data[LW-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_fire) begin
                case (i_ctrl.op)
                    cpid_pkg::OP_LOAD: begin
                        if (i_clear_history) begin
                            for (int i = 0; i < 2; i++) begin
                                r_prev[i]  <= '0;
                                r_integ[i] <= '0;
                            end
                        end
                    end
                    cpid_pkg::OP_DIFF:  r_prev[lp]  <= r_err;
                    cpid_pkg::OP_INTEG: r_integ[lp] <= W'(integ_v);
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            if (i_ctrl.mul != cpid_pkg::MUL_NONE) begin
                r_prod <= mul_a * mul_b;
            end
            case (i_ctrl.op)
                cpid_pkg::OP_LOAD: begin
                    r_sp  <= i_angle_setpoint;
                    r_am  <= i_angle_measured;
                    r_sm  <= i_speed_measured;
                end
                cpid_pkg::OP_ERR:        r_err <= err_v;
                cpid_pkg::OP_DIFF:       r_dd  <= dd_v;
                cpid_pkg::OP_TERM_FIRST: r_acc <= ACW'(term);
                cpid_pkg::OP_TERM_ADD:   r_acc <= r_acc + ACW'(term);
                cpid_pkg::OP_SUM: begin
                    if (lp == cpid_pkg::LOOP_INNER) begin
                        r_drv <= out_v;
                    end else begin
                        r_spd <= out_v;
                    end
                end
                cpid_pkg::OP_EMIT: begin
                    o_drive_value    <= r_drv;
                    o_speed_setpoint <= r_spd;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: hdl/cascade_pid_controller_unit.sv
// Top level of the cascade PID controller: microprogram sequencer and handshakes.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one word: angle setpoint,
//   angle measurement, speed measurement and a clear flag. Output channel
//   (o_out_valid / i_out_ready) returns the drive value and the outer loop's
//   speed setpoint. Gains and output limits are written through i_cfg_we,
//   i_cfg_index and i_cfg_data; the user must write them only while the block
//   is idle, as the block does not enforce this. A 14-step microprogram runs
//   both loops on one shared 32x32 multiplier and one adder/clamp unit: 6 steps
//   per loop, one load step, one emit step. The result is registered by the
//   emit step, and a new word is taken in the cycle after that step fires; no
//   new word is accepted while one is in flight. Each loop needs three
//   multiplies. Reset clears the gains, limits, loop history and the output
//   valid flag. If the receiver stalls, the next input word is still taken and
//   computed; the sequencer then holds in the emit step and the output word
//   stays until taken. No input is accepted while it holds.
module cascade_pid_controller_unit #(
    parameter int OUTER_INT_LIMIT = 65536000,
    parameter int INNER_INT_LIMIT = 65536000,
    parameter int OUTER_DEADZONE  = 0,
    parameter int INNER_DEADZONE  = 0,
    parameter int FRAC_BITS       = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [cpid_pkg::DATA_W-1:0]  i_angle_setpoint,
    input  logic signed [cpid_pkg::DATA_W-1:0]  i_angle_measured,
    input  logic signed [cpid_pkg::DATA_W-1:0]  i_speed_measured,
    input  logic                                i_clear_history,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [cpid_pkg::DATA_W-1:0]  o_drive_value,
    output logic signed [cpid_pkg::DATA_W-1:0]  o_speed_setpoint,
    input  logic                                i_cfg_we,
    input  logic [cpid_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cpid_pkg::DATA_W-1:0]         i_cfg_data
);

    logic [cpid_pkg::STEP_W-1:0] r_step, n_step;
    logic                        r_out_valid, n_out_valid;
    cpid_pkg::t_ctrl             ctrl;
    logic                        fire;

    assign ctrl = cpid_pkg::ucode(r_step);

    always_comb begin
        unique case (ctrl.jmp)
            cpid_pkg::JMP_WAIT_IN:  fire = i_in_valid;
            cpid_pkg::JMP_WAIT_OUT: fire = !r_out_valid || i_out_ready;
            default:                fire = 1'b1;
        endcase

        n_step = r_step;
        if (fire) begin
            if (ctrl.jmp == cpid_pkg::JMP_GOTO || ctrl.jmp == cpid_pkg::JMP_WAIT_OUT) begin
                n_step = ctrl.target;
            end else begin
                n_step = r_step + 1'b1;
            end
        end

        n_out_valid = r_out_valid && !i_out_ready;
        if (fire && ctrl.op == cpid_pkg::OP_EMIT) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= cpid_pkg::STEP_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (ctrl.jmp == cpid_pkg::JMP_WAIT_IN);
    assign o_out_valid = r_out_valid;

    cpid_datapath #(
        .OUTER_INT_LIMIT (OUTER_INT_LIMIT),
        .INNER_INT_LIMIT (INNER_INT_LIMIT),
        .OUTER_DEADZONE  (OUTER_DEADZONE),
        .INNER_DEADZONE  (INNER_DEADZONE),
        .FRAC_BITS       (FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (ctrl),
        .i_fire           (fire),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_angle_setpoint (i_angle_setpoint),
        .i_angle_measured (i_angle_measured),
        .i_speed_measured (i_speed_measured),
        .i_clear_history  (i_clear_history),
        .o_drive_value    (o_drive_value),
        .o_speed_setpoint (o_speed_setpoint)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again right after accept");

    a_emit_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_step) == cpid_pkg::STEP_EMIT)
        else $error("output valid raised outside the emit step");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= cpid_pkg::STEP_EMIT)
        else $error("step counter left the microprogram");

endmodule
